>>> design/table_driven_dfa_recognizer_core_assert.svh
// Assertion macros used by the checker file of the DFA recognizer core.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef TABLE_DRIVEN_DFA_RECOGNIZER_CORE_ASSERT_SVH
`define TABLE_DRIVEN_DFA_RECOGNIZER_CORE_ASSERT_SVH

// Property checked while reset is released, fixed failure text.
`define TDFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tdfa assertion failed");

// Same, with a caller supplied failure text.
`define TDFA_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> design/tdfa_pkg.sv
// Shared types and constants of the table-driven DFA recognizer core.
// No dependencies; imported by every module of the block.
`default_nettype none

package tdfa_pkg;

  localparam int MAX_STATES  = 16;
  localparam int MAX_SYMBOLS = 16;

  localparam int STATE_W  = $clog2(MAX_STATES);
  localparam int COL_W    = $clog2(MAX_SYMBOLS);
  localparam int SIZE_W   = COL_W + 1;
  localparam int SYM_W    = 8;
  localparam int ENTRY_W  = STATE_W + 1;

  // stream widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  // result beat layout
  localparam int OUT_BEFORE_LSB = 0;
  localparam int OUT_AFTER_LSB  = STATE_W;
  localparam int OUT_DEAD_BIT   = 2 * STATE_W;
  localparam int OUT_ACC_BIT    = 2 * STATE_W + 1;
  localparam int OUT_USED_W     = 2 * STATE_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    ACT_TRANS = 2'd0,
    ACT_ALPHA = 2'd1,
    ACT_FINAL = 2'd2,
    ACT_FEED  = 2'd3
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_STATE = 1'd0,
    CFG_ALPHABET_SIZE = 1'd1
  } cfg_idx_e;

  // transition entry: dead mark above the target state
  typedef struct packed {
    logic               dead;
    logic [STATE_W-1:0] target;
  } entry_t;

  typedef entry_t [MAX_SYMBOLS-1:0] row_t;

  typedef struct packed {
    act_e               action;
    logic [STATE_W-1:0] state_index;
    logic [COL_W-1:0]   column_index;
    logic [STATE_W-1:0] next_state;
    logic               next_is_dead;
    logic [SYM_W-1:0]   symbol;
    logic               is_final;
    logic               has_symbol;
    logic               last_of_word;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
  } match_t;

  typedef struct packed {
    logic [STATE_W-1:0] state_before;
    logic [STATE_W-1:0] state_after;
    logic               dead;
    logic               word_done;
    logic               accepted;
  } res_t;

endpackage

`default_nettype wire

>>> design/table_driven_dfa_recognizer_core.sv
// Top level of the table-driven DFA recognizer core.
// Depends on tdfa_pkg, tdfa_alpha_match, tdfa_trans_ram and tdfa_out_reg.
//
// Usage:
//   s_axis carries load and feed beats; tuser[1:0] is the action, tuser[2] the
//   has_symbol flag, tlast marks a word's last feed beat. Load beats (table
//   entry, alphabet slot, final flag) give no result; every feed beat gives
//   exactly one result beat on m_axis, tlast set on a word's last result.
//   cfg_we_i/cfg_idx_i/cfg_data_i write initial_state and alphabet_size;
//   write them only while no beat is in flight.
// Path: a feed beat passes the input register, then the result register, before it shows on m_axis.
// Throughput: one beat per cycle while the result register has room. The current
//   state's table row comes from a registered read addressed with the next state
//   (next-state address into the row RAM), so the state loop is one RAM read plus a column select per cycle.
// Reset: the state and dead flag clear, the next feed beat starts a word, all
//   final flags clear. Table and alphabet contents are not cleared.
// Stall: while m_axis_tready is low and a result waits, one more beat is held
//   in the input register; s_axis_tready then drops. Load beats keep flowing
//   as long as the input register drains.
`default_nettype none

module table_driven_dfa_recognizer_core import tdfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input beats
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] state_index, [7:4] column_index, [11:8] next_state,
  // [12] next_is_dead, [20:13] symbol, [21] is_final, [23:22] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] action, [2] has_symbol
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  s_axis_tlast,
  // result beats
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [3:0] state_before, [7:4] state_after, [8] dead, [9] accepted, [15:10] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // input register
  logic  in_vld_q;
  item_t in_q, in_d;
  logic  adv, out_free;

  always_comb begin
    in_d.action       = act_e'(s_axis_tuser[1:0]);
    in_d.has_symbol   = s_axis_tuser[2];
    in_d.state_index  = s_axis_tdata[3:0];
    in_d.column_index = s_axis_tdata[7:4];
    in_d.next_state   = s_axis_tdata[11:8];
    in_d.next_is_dead = s_axis_tdata[12];
    in_d.symbol       = s_axis_tdata[20:13];
    in_d.is_final     = s_axis_tdata[21];
    in_d.last_of_word = s_axis_tlast;
  end

  // loads never wait; a feed waits for room in the result register
  assign adv           = in_vld_q && ((in_q.action != ACT_FEED) || out_free);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_d;
    end
  end

  // word state and configuration
  logic [STATE_W-1:0]    cur_q, cur_d;
  logic                  dead_q, dead_d;
  logic                  start_q, start_d;
  logic [STATE_W-1:0]    init_q, init_d;
  logic [SIZE_W-1:0]     size_q, size_d;
  logic [MAX_STATES-1:0] final_q, final_d;

  logic feed, tbl_we, alpha_we;
  assign feed     = adv && (in_q.action == ACT_FEED);
  assign tbl_we   = adv && (in_q.action == ACT_TRANS);
  assign alpha_we = adv && (in_q.action == ACT_ALPHA);

  match_t             match;
  row_t               row;
  entry_t             entry, wr_entry;
  logic [STATE_W-1:0] eff_state, state_n, rd_row;
  logic               eff_dead, step, dead_n;
  res_t               res;

  tdfa_alpha_match u_alpha (
    .clk_i   (clk_i),
    .we_i    (alpha_we),
    .slot_i  (in_q.column_index),
    .byte_i  (in_q.symbol),
    .size_i  (size_q),
    .sym_i   (in_q.symbol),
    .match_o (match)
  );

  assign wr_entry.dead   = in_q.next_is_dead;
  assign wr_entry.target = in_q.next_state;

  // row holds the table row of eff_state, from a registered read addressed with the next state
  tdfa_trans_ram u_ram (
    .clk_i      (clk_i),
    .we_i       (tbl_we),
    .wr_row_i   (in_q.state_index),
    .wr_col_i   (in_q.column_index),
    .wr_entry_i (wr_entry),
    .rd_row_i   (rd_row),
    .rd_row_o   (row)
  );

  // a word's first feed beat starts from initial_state, live
  assign eff_state = start_q ? init_q : cur_q;
  assign eff_dead  = start_q ? 1'b0 : dead_q;
  assign entry     = row[match.col];
  assign step      = !eff_dead && in_q.has_symbol;
  assign dead_n    = eff_dead || (step && (!match.hit || entry.dead));

  always_comb begin
    if (dead_n) begin
      state_n = '0;
    end else if (step) begin
      state_n = entry.target;
    end else begin
      state_n = eff_state;
    end
  end

  always_comb begin
    res.state_before = eff_dead ? '0 : eff_state;
    res.state_after  = state_n;
    res.dead         = dead_n;
    res.word_done    = in_q.last_of_word;
    res.accepted     = in_q.last_of_word && !dead_n && final_q[state_n];
  end

  always_comb begin
    cur_d   = cur_q;
    dead_d  = dead_q;
    start_d = start_q;
    init_d  = init_q;
    size_d  = size_q;
    final_d = final_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INITIAL_STATE: init_d = cfg_data_i[STATE_W-1:0];
        CFG_ALPHABET_SIZE: size_d = cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
    if (feed) begin
      cur_d   = state_n;
      dead_d  = dead_n;
      start_d = in_q.last_of_word;
    end
    if (adv && (in_q.action == ACT_FINAL)) begin
      final_d[in_q.state_index] = in_q.is_final;
    end
  end

  assign rd_row = start_d ? init_d : cur_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      dead_q  <= 1'b0;
      start_q <= 1'b1;
      init_q  <= '0;
      size_q  <= SIZE_W'(1);
      final_q <= '0;
    end else begin
      cur_q   <= cur_d;
      dead_q  <= dead_d;
      start_q <= start_d;
      init_q  <= init_d;
      size_q  <= size_d;
      final_q <= final_d;
    end
  end

  tdfa_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (feed),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> design/tdfa_alpha_match.sv
// Alphabet symbol registers and the parallel first-match column lookup.
// Depends on tdfa_pkg.
`default_nettype none

module tdfa_alpha_match import tdfa_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [COL_W-1:0]  slot_i,
  input  logic [SYM_W-1:0]  byte_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [SYM_W-1:0]  sym_i,
  output match_t            match_o
);

  logic [SYM_W-1:0] alpha_q [MAX_SYMBOLS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      alpha_q[slot_i] <= byte_i;
    end
  end

  // walk downward so the lowest matching slot wins
  always_comb begin
    match_o = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((SIZE_W'(i) < size_i) && (alpha_q[i] == sym_i)) begin
        match_o.hit = 1'b1;
        match_o.col = COL_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/tdfa_trans_ram.sv
// Transition table memory: one row per state, entry-masked writes and a
// registered whole-row read with write-through for the row being read.
// Depends on tdfa_pkg.
`default_nettype none

module tdfa_trans_ram import tdfa_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [STATE_W-1:0] wr_row_i,
  input  logic [COL_W-1:0]   wr_col_i,
  input  entry_t             wr_entry_i,
  input  logic [STATE_W-1:0] rd_row_i,
  output row_t               rd_row_o
);

  row_t mem_q [MAX_STATES];
  row_t rd_q;

  logic             byp_q;
  logic [COL_W-1:0] byp_col_q;
  entry_t           byp_entry_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_row_i][wr_col_i] <= wr_entry_i;
    end
    rd_q        <= mem_q[rd_row_i];
    byp_q       <= we_i && (wr_row_i == rd_row_i);
    byp_col_q   <= wr_col_i;
    byp_entry_q <= wr_entry_i;
  end

  // an entry written into the row read this cycle is merged in after the read
  always_comb begin
    rd_row_o = rd_q;
    if (byp_q) begin
      rd_row_o[byp_col_q] = byp_entry_q;
    end
  end

endmodule

`default_nettype wire

>>> design/tdfa_out_reg.sv
// Result register of the recognizer: holds one result beat for the sink.
// Depends on tdfa_pkg.
`default_nettype none

module tdfa_out_reg import tdfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  res_t                  res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [OUT_DATA_W-1:0] data_o,
  output logic                  last_o
);

  logic vld_q, vld_d;
  res_t res_q;

  assign free_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign last_o  = res_q.word_done;
  assign data_o  = {(OUT_DATA_W - OUT_USED_W)'(0), res_q.accepted, res_q.dead,
                    res_q.state_after, res_q.state_before};

endmodule

`default_nettype wire

>>> design/tdfa_checker.sv
// Port-level checks of the DFA recognizer core, bound to the top level.
// Depends on tdfa_pkg and table_driven_dfa_recognizer_core_assert.svh.
`default_nettype none
`include "table_driven_dfa_recognizer_core_assert.svh"

module tdfa_checker import tdfa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // a stalled result beat holds
  `TDFA_ASSERT_MSG(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled result beat changed")

  // a dead word reports state 0 after the step
  `TDFA_ASSERT(a_dead_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[OUT_DEAD_BIT] |-> m_axis_tdata[OUT_AFTER_LSB +: STATE_W] == '0))

  // acceptance only on a live word's last beat
  `TDFA_ASSERT(a_acc_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[OUT_ACC_BIT] |-> m_axis_tlast && !m_axis_tdata[OUT_DEAD_BIT]))

  // a result appearing on an idle output came from an accepted feed beat
  `TDFA_ASSERT_MSG(a_out_src, clk_i, rst_ni, ($rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == ACT_FEED), 2)), "result without a feed beat")

endmodule

bind table_driven_dfa_recognizer_core tdfa_checker u_tdfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/table_driven_dfa_recognizer_core_tb.sv
// Testbench for table_driven_dfa_recognizer_core: loads tables, runs directed and random
// words through the automaton and checks every result beat against an in-bench predictor.
// Depends on tdfa_pkg and the core RTL only.
`timescale 1ns / 100ps

module table_driven_dfa_recognizer_core_tb;
  import tdfa_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES   = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  table_driven_dfa_recognizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // automaton mirror
  entry_t             tbl_entry [MAX_STATES*MAX_SYMBOLS];
  logic [SYM_W-1:0]   alpha_byte [MAX_SYMBOLS];
  logic               final_bit [MAX_STATES];
  logic [STATE_W-1:0] cur_state;
  logic               word_dead;
  logic               word_fresh;
  logic [STATE_W-1:0] init_state;
  logic [SIZE_W-1:0]  alpha_count;

  res_t expected_steps[$];
  int   err_count;
  int   items_sent;
  int   cycle_count;
  bit   tx_idle_on;
  bit   rx_idle_on;
  logic hold_off_req;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one step of the automaton; feed beats queue the result they must produce
  task automatic dfa_predict(input item_t it);
    res_t r;
    int   n;
    int   col;
    bit   hit;
    entry_t e;
    unique case (it.action)
      ACT_TRANS: tbl_entry[{it.state_index, it.column_index}] = {it.next_is_dead, it.next_state};
      ACT_ALPHA: alpha_byte[it.column_index] = it.symbol;
      ACT_FINAL: final_bit[it.state_index] = it.is_final;
      ACT_FEED: begin
        if (word_fresh) begin
          cur_state  = init_state;
          word_dead  = 1'b0;
          word_fresh = 1'b0;
        end
        r.state_before = word_dead ? '0 : cur_state;
        if (!word_dead && it.has_symbol) begin
          n   = (alpha_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(alpha_count);
          hit = 1'b0;
          col = 0;
          for (int i = 0; i < n; i++)
            if (!hit && alpha_byte[i] == it.symbol) begin
              hit = 1'b1;
              col = i;
            end
          if (!hit) begin
            word_dead = 1'b1;
          end else begin
            e = tbl_entry[int'(cur_state) * MAX_SYMBOLS + col];
            if (e.dead) word_dead = 1'b1;
            else cur_state = e.target;
          end
        end
        if (word_dead) cur_state = '0;
        r.state_after = cur_state;
        r.dead        = word_dead;
        r.word_done   = it.last_of_word;
        r.accepted    = it.last_of_word && !word_dead && final_bit[cur_state];
        expected_steps = {expected_steps, r};
        if (it.last_of_word) word_fresh = 1'b1;
      end
      default: ;
    endcase
  endtask

  // called in a rising-edge time step; returns in the step where the beat was taken
  task automatic send_item(input item_t it);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.is_final, it.symbol, it.next_is_dead, it.next_state,
                      it.column_index, it.state_index};
    s_axis_tuser  <= {it.has_symbol, it.action};
    s_axis_tlast  <= it.last_of_word;
    do @(posedge clk_i); while (!s_axis_tready);
    dfa_predict(it);
    items_sent++;
  endtask

  function automatic item_t random_item();
    logic [$bits(item_t)-1:0] raw;
    raw = $bits(item_t)'($urandom);
    return item_t'(raw);
  endfunction

  task automatic feed(input logic [SYM_W-1:0] sym, input bit has_sym, input bit last);
    item_t it;
    it              = random_item();
    it.action       = ACT_FEED;
    it.symbol       = sym;
    it.has_symbol   = has_sym;
    it.last_of_word = last;
    send_item(it);
  endtask

  task automatic load_trans(input int row, input int col, input int nxt, input bit dead);
    item_t it;
    it              = random_item();
    it.action       = ACT_TRANS;
    it.state_index  = row[STATE_W-1:0];
    it.column_index = col[COL_W-1:0];
    it.next_state   = nxt[STATE_W-1:0];
    it.next_is_dead = dead;
    send_item(it);
  endtask

  task automatic load_alpha(input int slot, input logic [SYM_W-1:0] sym);
    item_t it;
    it              = random_item();
    it.action       = ACT_ALPHA;
    it.column_index = slot[COL_W-1:0];
    it.symbol       = sym;
    send_item(it);
  endtask

  task automatic load_final(input int st, input bit flag);
    item_t it;
    it             = random_item();
    it.action      = ACT_FINAL;
    it.state_index = st[STATE_W-1:0];
    it.is_final    = flag;
    send_item(it);
  endtask

  // stop offering beats until every result is back, then let the pipe go quiet
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_INITIAL_STATE) init_state = data[STATE_W-1:0];
    else alpha_count = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    int n;
    n = (alpha_count > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(alpha_count);
    if (n == 0 || $urandom_range(0, 15) == 0) return SYM_W'($urandom);
    return alpha_byte[$urandom_range(0, n - 1)];
  endfunction

  function automatic logic [SYM_W-1:0] foreign_symbol();
    logic [SYM_W-1:0] b;
    bit clash;
    b = 8'h01;
    do begin
      clash = 1'b0;
      for (int i = 0; i < MAX_SYMBOLS; i++)
        if (alpha_byte[i] == b) clash = 1'b1;
      if (clash) b++;
    end while (clash);
    return b;
  endfunction

  // one word with the odd load mixed in; length 0 is the empty word
  task automatic feed_word(input int len);
    item_t it;
    if (len == 0) begin
      feed(SYM_W'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        it        = random_item();
        it.action = act_e'($urandom_range(0, 2));
        if (it.action == ACT_TRANS) it.next_is_dead = ($urandom_range(0, 7) == 0);
        send_item(it);
      end
      feed(pick_symbol(), $urandom_range(0, 15) != 0, k == len - 1);
    end
  endtask

  task automatic test_empty_words();
    feed(8'h00, 1'b0, 1'b1);
    feed(8'hff, 1'b0, 1'b0);
    feed(8'h5a, 1'b0, 1'b1);
    load_final(0, 1'b1);
    feed(8'ha5, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_table_load();
    cfg_write(CFG_ALPHABET_SIZE, 5'd16);
    for (int i = 0; i < MAX_SYMBOLS; i++) load_alpha(i, SYM_W'(i * 17));
    for (int s = 0; s < MAX_STATES; s++)
      for (int c = 0; c < MAX_SYMBOLS; c++)
        load_trans(s, c, $urandom_range(0, MAX_STATES - 1), $urandom_range(0, 9) == 0);
    for (int s = 0; s < MAX_STATES; s++) load_final(s, $urandom_range(0, 1) == 1);
    drain_results();
  endtask

  task automatic test_directed_words();
    // plain walk through the table, both byte extremes
    feed(alpha_byte[0], 1'b1, 1'b0);
    feed(alpha_byte[15], 1'b1, 1'b0);
    feed(alpha_byte[7], 1'b1, 1'b1);
    // byte outside the alphabet, dead sticks through a symbol-less beat
    feed(alpha_byte[1], 1'b1, 1'b0);
    feed(foreign_symbol(), 1'b1, 1'b0);
    feed(8'h00, 1'b0, 1'b0);
    feed(alpha_byte[2], 1'b1, 1'b1);
    // entry marked dead
    load_trans(init_state, 4, 0, 1'b1);
    feed(alpha_byte[4], 1'b1, 1'b1);
    // duplicate byte in a later slot: the earlier slot wins
    load_alpha(9, alpha_byte[3]);
    feed(alpha_byte[3], 1'b1, 1'b1);
    // loads in the middle of a word
    load_trans(init_state, 5, 6, 1'b0);
    feed(alpha_byte[5], 1'b1, 1'b0);
    load_final(cur_state, 1'b1);
    feed(8'h00, 1'b0, 1'b1);
    drain_results();
    // no alphabet slot compared: every byte goes dead
    cfg_write(CFG_ALPHABET_SIZE, 5'd0);
    feed(alpha_byte[0], 1'b1, 1'b1);
    feed(alpha_byte[0], 1'b0, 1'b1);
    drain_results();
    // oversized alphabet clamps to the full slot count
    cfg_write(CFG_ALPHABET_SIZE, 5'd31);
    cfg_write(CFG_INITIAL_STATE, 5'd15);
    feed(alpha_byte[15], 1'b1, 1'b0);
    feed(alpha_byte[0], 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    int start;
    hold_off_req <= 1'b1;
    start = items_sent;
    while (items_sent - start < 40) feed_word($urandom_range(1, 8));
    drain_results();
  endtask

  task automatic test_random_phase(input int n_items, input logic [CFG_DATA_W-1:0] init,
                                   input logic [CFG_DATA_W-1:0] size);
    int start;
    cfg_write(CFG_INITIAL_STATE, init);
    cfg_write(CFG_ALPHABET_SIZE, size);
    start = items_sent;
    while (items_sent - start < n_items) feed_word($urandom_range(0, 8));
    drain_results();
  endtask

  // result checker
  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_steps.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        err_count++;
      end else begin
        exp_r = expected_steps.pop_front();
        check_field("state_before", exp_r.state_before,
                    m_axis_tdata[OUT_BEFORE_LSB +: STATE_W]);
        check_field("state_after", exp_r.state_after, m_axis_tdata[OUT_AFTER_LSB +: STATE_W]);
        check_field("dead", exp_r.dead, m_axis_tdata[OUT_DEAD_BIT]);
        check_field("word_done", exp_r.word_done, m_axis_tlast);
        check_field("accepted", exp_r.accepted, m_axis_tdata[OUT_ACC_BIT]);
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    hold_off_req  = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    cycle_count   = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    for (int s = 0; s < MAX_STATES; s++) final_bit[s] = 1'b0;
    cur_state   = '0;
    word_dead   = 1'b0;
    word_fresh  = 1'b1;
    init_state  = '0;
    alpha_count = SIZE_W'(1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_words();
    test_table_load();
    test_directed_words();
    test_backpressure();
    test_random_phase(350, 5'd0, 5'd16);
    test_random_phase(300, 5'd15, 5'd1);
    test_random_phase(300, 5'($urandom_range(0, 31)), 5'($urandom_range(2, 15)));
    test_random_phase(150, 5'($urandom_range(0, 31)), 5'd0);
    test_random_phase(350, 5'($urandom_range(0, 31)), 5'd31);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_phase(400, 5'($urandom_range(0, 31)), 5'($urandom_range(1, 16)));

    repeat (8) @(posedge clk_i);
    if (expected_steps.size() != 0) begin
      $error("%0d results never arrived", expected_steps.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/tdfa_pkg.sv
design/tdfa_alpha_match.sv
design/tdfa_trans_ram.sv
design/tdfa_out_reg.sv
design/table_driven_dfa_recognizer_core.sv
design/tdfa_checker.sv
tb/table_driven_dfa_recognizer_core_tb.sv
